### rtl/rpu_pkg.sv
`timescale 1ns / 1ps

package rpu_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [1:0] REG_DECAY_FACTOR = 2'd1;
  localparam logic [1:0] REG_EPSILON      = 2'd2;
  localparam logic [1:0] REG_WEIGHT_DECAY = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] LEARN_RATE_RST   = 24'd16777;
  localparam logic [15:0] DECAY_FACTOR_RST = 16'd64881;
  localparam logic [15:0] EPSILON_RST      = 16'd1;
  localparam logic [23:0] WEIGHT_DECAY_RST = 24'd0;

  // 1.0 in Q1.16, used for the complement of beta.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Square root: one result bit per stage over a 48-bit radicand.
  localparam int SQ_N = 24;
  // Division: quotient bits kept below the overflow point.
  localparam int DIV_N = 34;

  typedef struct packed {
    logic signed [31:0] param_in;
    logic signed [31:0] grad_in;
    logic        [31:0] sqavg_in;
  } rpu_in_t;

  typedef struct packed {
    logic signed [31:0] param_out;
    logic        [31:0] sqavg_out;
  } rpu_out_t;

endpackage

### rtl/rmsprop_param_update_core.sv
`timescale 1ns / 1ps

// RMSProp parameter update, one parameter element per beat, fully pipelined.
// Each input beat carries a parameter, its gradient and its stored squared-gradient
// average (all Q16.16); each output beat carries the updated parameter and the
// updated average, both saturated. A new beat can be taken every cycle unless
// in_stall is high. The pipeline has three multiply stages, a 24-stage square
// root (one root bit per stage), one stage forming the denominator, a 34-stage
// restoring divider (one quotient bit per stage) and the output register. The
// whole pipeline advances together; when the output register holds a beat that
// the consumer stalls, in_stall rises and every stage holds.
// Configuration registers may only be written while no beat is in flight.
module rmsprop_param_update_core
  import rpu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rpu_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rpu_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [23:0] learn_rate_r;
  logic [15:0] decay_factor_r;
  logic [15:0] epsilon_r;
  logic [23:0] weight_decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= LEARN_RATE_RST;
      decay_factor_r <= DECAY_FACTOR_RST;
      epsilon_r      <= EPSILON_RST;
      weight_decay_r <= WEIGHT_DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:   learn_rate_r   <= cfg_data[23:0];
        REG_DECAY_FACTOR: decay_factor_r <= cfg_data[15:0];
        REG_EPSILON:      epsilon_r      <= cfg_data[15:0];
        REG_WEIGHT_DECAY: weight_decay_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves when the output register is free or being drained.
  logic     out_valid_r;
  rpu_out_t out_data_r;
  logic     adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage A: squared gradient magnitude and the weight-decay product.
  logic               a_vld_r;
  logic signed [31:0] a_p_r;
  logic signed [31:0] a_g_r;
  logic        [31:0] a_v_r;
  logic        [46:0] a_g2_r;
  logic signed [56:0] a_wdp_r;

  logic [31:0] gmag;
  logic [63:0] gsq;

  always_comb begin
    gmag = in_data.grad_in[31] ? (~in_data.grad_in + 32'd1) : in_data.grad_in;
    gsq  = gmag * gmag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p_r   <= in_data.param_in;
      a_g_r   <= in_data.grad_in;
      a_v_r   <= in_data.sqavg_in;
      a_g2_r  <= gsq[62:16];
      a_wdp_r <= $signed({1'b0, weight_decay_r}) * in_data.param_in;
    end
  end

  // Stage B: average accumulator and the effective gradient.
  logic               b_vld_r;
  logic signed [31:0] b_p_r;
  logic        [63:0] b_acc_r;
  logic signed [32:0] b_eff_r;

  logic [47:0]        beta_v;
  logic [63:0]        beta_g2;
  logic [16:0]        beta_c;
  logic signed [31:0] wd_term;

  always_comb begin
    beta_c  = ONE_Q16 - {1'b0, decay_factor_r};
    beta_v  = decay_factor_r * a_v_r;
    beta_g2 = beta_c * a_g2_r;
    // The product stays inside 56 signed bits, so this is floor(wd*p / 2^24).
    wd_term = a_wdp_r[55:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p_r   <= a_p_r;
      b_acc_r <= {16'd0, beta_v} + beta_g2;
      b_eff_r <= {a_g_r[31], a_g_r} + {wd_term[31], wd_term};
    end
  end

  // Stage C feeds the square root chain as its entry zero. It holds the
  // saturated new average, the numerator lr*eff and the parameter.
  logic               sq_vld_r  [SQ_N+1];
  logic        [31:0] sq_avg_r  [SQ_N+1];
  logic signed [57:0] sq_num_r  [SQ_N+1];
  logic signed [31:0] sq_p_r    [SQ_N+1];
  logic        [25:0] sq_rem_r  [SQ_N+1];
  logic        [23:0] sq_root_r [SQ_N+1];

  logic        [25:0] sq_rem_nxt  [SQ_N];
  logic        [23:0] sq_root_nxt [SQ_N];
  logic        [47:0] sq_x        [SQ_N];
  logic        [27:0] sq_trial    [SQ_N];
  logic        [27:0] sq_cand     [SQ_N];

  logic [31:0] avg_sat;

  assign avg_sat = (|b_acc_r[63:48]) ? 32'hFFFF_FFFF : b_acc_r[47:16];

  // Each stage brings down the next two radicand bits and decides one root bit.
  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_x[k]     = {sq_avg_r[k], 16'd0};
      sq_trial[k] = {sq_rem_r[k], sq_x[k][47-2*k -: 2]};
      sq_cand[k]  = {2'b00, sq_root_r[k], 2'b01};
      if (sq_trial[k] >= sq_cand[k]) begin
        sq_rem_nxt[k]  = 26'(sq_trial[k] - sq_cand[k]);
        sq_root_nxt[k] = {sq_root_r[k][22:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = sq_trial[k][25:0];
        sq_root_nxt[k] = {sq_root_r[k][22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_N; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      sq_vld_r[0] <= b_vld_r;
      for (int k = 0; k < SQ_N; k++) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_avg_r[0]  <= avg_sat;
      sq_num_r[0]  <= $signed({1'b0, learn_rate_r}) * b_eff_r;
      sq_p_r[0]    <= b_p_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      for (int k = 0; k < SQ_N; k++) begin
        sq_avg_r[k+1]  <= sq_avg_r[k];
        sq_num_r[k+1]  <= sq_num_r[k];
        sq_p_r[k+1]    <= sq_p_r[k];
        sq_rem_r[k+1]  <= sq_rem_nxt[k];
        sq_root_r[k+1] <= sq_root_nxt[k];
      end
    end
  end

  // Stage D is the divider's entry zero. The quotient is floor(|num| / 2^8 / den);
  // anything at or above 2^34 saturates the parameter anyway, so the upper
  // dividend bits only decide overflow and become the starting remainder.
  logic               dv_vld_r  [DIV_N+1];
  logic        [31:0] dv_avg_r  [DIV_N+1];
  logic signed [31:0] dv_p_r    [DIV_N+1];
  logic               dv_neg_r  [DIV_N+1];
  logic               dv_zero_r [DIV_N+1];
  logic               dv_ovf_r  [DIV_N+1];
  logic        [24:0] dv_den_r  [DIV_N+1];
  logic        [24:0] dv_rem_r  [DIV_N+1];
  logic        [33:0] dv_lo_r   [DIV_N+1];
  logic        [33:0] dv_q_r    [DIV_N+1];

  logic [24:0] den;
  logic [57:0] nmag;
  logic [48:0] nsh;
  logic        ovf;

  always_comb begin
    den  = {1'b0, sq_root_r[SQ_N]} + {9'd0, epsilon_r};
    nmag = sq_num_r[SQ_N][57] ? 58'(-sq_num_r[SQ_N]) : sq_num_r[SQ_N];
    nsh  = nmag[56:8];
    ovf  = {10'd0, nsh[48:34]} >= den;
  end

  logic [25:0] dv_t   [DIV_N];
  logic        dv_ge  [DIV_N];
  logic [24:0] dv_rem_nxt [DIV_N];

  always_comb begin
    for (int k = 0; k < DIV_N; k++) begin
      dv_t[k]  = {dv_rem_r[k], dv_lo_r[k][33]};
      dv_ge[k] = dv_t[k] >= {1'b0, dv_den_r[k]};
      dv_rem_nxt[k] = dv_ge[k] ? 25'(dv_t[k] - {1'b0, dv_den_r[k]}) : dv_t[k][24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_N; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_vld_r[0] <= sq_vld_r[SQ_N];
      for (int k = 0; k < DIV_N; k++) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_avg_r[0]  <= sq_avg_r[SQ_N];
      dv_p_r[0]    <= sq_p_r[SQ_N];
      dv_neg_r[0]  <= sq_num_r[SQ_N][57];
      dv_zero_r[0] <= (sq_num_r[SQ_N] == '0);
      dv_ovf_r[0]  <= ovf;
      dv_den_r[0]  <= den;
      dv_rem_r[0]  <= {10'd0, nsh[48:34]};
      dv_lo_r[0]   <= nsh[33:0];
      dv_q_r[0]    <= '0;
      for (int k = 0; k < DIV_N; k++) begin
        dv_avg_r[k+1]  <= dv_avg_r[k];
        dv_p_r[k+1]    <= dv_p_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_ovf_r[k+1]  <= dv_ovf_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_rem_r[k+1]  <= dv_rem_nxt[k];
        dv_lo_r[k+1]   <= {dv_lo_r[k][32:0], 1'b0};
        dv_q_r[k+1]    <= {dv_q_r[k][32:0], dv_ge[k]};
      end
    end
  end

  // Output stage: apply the step and saturate. A zero numerator leaves the
  // parameter alone; an overflowed quotient (this covers a zero denominator)
  // drives the parameter to the rail opposite the numerator's sign.
  logic signed [35:0] pe;
  logic signed [35:0] qe;
  logic signed [35:0] res;
  rpu_out_t           out_nxt;

  always_comb begin
    pe  = {{4{dv_p_r[DIV_N][31]}}, dv_p_r[DIV_N]};
    qe  = {2'b00, dv_q_r[DIV_N]};
    res = dv_neg_r[DIV_N] ? (pe + qe) : (pe - qe);
    out_nxt.sqavg_out = dv_avg_r[DIV_N];
    if (dv_zero_r[DIV_N]) begin
      out_nxt.param_out = dv_p_r[DIV_N];
    end else if (dv_ovf_r[DIV_N]) begin
      out_nxt.param_out = dv_neg_r[DIV_N] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end else if (!res[35] && (|res[34:31])) begin
      out_nxt.param_out = 32'sh7FFF_FFFF;
    end else if (res[35] && !(&res[34:31])) begin
      out_nxt.param_out = 32'sh8000_0000;
    end else begin
      out_nxt.param_out = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/tb_rmsprop_param_update_core.sv
`timescale 1ns / 1ps

module tb_rmsprop_param_update_core;
  import rpu_pkg::*;

  // The scoreboard keeps its own copy of the four registers. For every beat
  // taken on the input it predicts the updated parameter and average. Each
  // beat on the output is then checked against the oldest prediction.
  class rmsprop_scoreboard;
    logic [23:0] lr;
    logic [15:0] beta;
    logic [15:0] eps;
    logic [23:0] wd;
    rpu_out_t    pending[$];
    int          errors;

    function new();
      lr = LEARN_RATE_RST;
      beta = DECAY_FACTOR_RST;
      eps = EPSILON_RST;
      wd = WEIGHT_DECAY_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_LEARN_RATE:   lr = val;
        REG_DECAY_FACTOR: beta = val[15:0];
        REG_EPSILON:      eps = val[15:0];
        REG_WEIGHT_DECAY: wd = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(rpu_in_t d);
      longint p;
      longint g;
      longint unsigned gm;
      longint unsigned g2;
      longint unsigned avg;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      longint prod;
      longint eff;
      longint num;
      longint np;
      rpu_out_t r;
      p = d.param_in;
      g = d.grad_in;
      gm = (g < 0) ? -g : g;
      g2 = (gm * gm) >> 16;
      avg = ({48'd0, beta} * {32'd0, d.sqavg_in} +
             (64'd65536 - beta) * g2) >> 16;
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
      den = int_sqrt(avg << 16) + eps;
      prod = longint'(wd) * p;
      // Floor shift so that negative products round toward minus infinity.
      eff = g + (prod >>> 24);
      num = longint'(lr) * eff;
      if (num == 0) begin
        np = p;
      end else if (den == 0) begin
        // Zero denominator: the quotient saturates in the direction of num.
        np = (num > 0) ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        mag = (num < 0) ? -num : num;
        q = mag / (den << 8);
        np = (num < 0) ? p + longint'(q) : p - longint'(q);
        if (np > 64'sd2147483647) np = 64'sd2147483647;
        if (np < -64'sd2147483648) np = -64'sd2147483648;
      end
      r.param_out = np[31:0];
      r.sqavg_out = avg[31:0];
      pending.push_back(r);
    endfunction

    task check_result(rpu_out_t got);
      rpu_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, got.param_out);
        return;
      end
      want = pending.pop_front();
      if (got.param_out !== want.param_out)
        report_mismatch("param_out", want.param_out, got.param_out);
      if (got.sqavg_out !== want.sqavg_out)
        report_mismatch("sqavg_out", want.sqavg_out, got.sqavg_out);
    endtask

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %h, got %h", what, want, got);
      errors++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rpu_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rpu_out_t out_data;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rmsprop_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  longint cycles;

  localparam int  PIPE_LAT = 63;
  localparam longint CYCLE_LIMIT = 400000;

  rmsprop_param_update_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random. Result beats are checked at the same edge
  // at which the block sees them accepted, using values from before the edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rmsprop_param_update_core: FAIL");
      $finish;
    end
  end

  // Present one beat and hold it until the block takes it. Random idle
  // cycles are inserted ahead of the beat according to the sender setting.
  // Valid stays high after the beat is taken so that back-to-back beats
  // need no second assignment in the same time step.
  task automatic send_beat(rpu_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d);
  endtask

  // Wait until every predicted beat has come back, then let the pipeline
  // drain a little more so that no beat is still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(131071) - 65536;
      3: return $urandom_range(8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int n);
    rpu_in_t d;
    for (int k = 0; k < n; k++) begin
      d.param_in = rand_word();
      d.grad_in  = rand_word();
      d.sqavg_in = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom;
      send_beat(d);
    end
  endtask

  task automatic send_fields(logic [31:0] p, logic [31:0] g, logic [31:0] v);
    rpu_in_t d;
    d.param_in = p;
    d.grad_in  = g;
    d.sqavg_in = v;
    send_beat(d);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 23;
    recv_idle_pct = 66;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at reset settings: field extremes and zero gradient.
    send_fields(32'h0, 32'h0, 32'h0);
    send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h0);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fields(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    drain();

    // Zero denominator: no epsilon and a zero average, both signs of num.
    write_reg(REG_EPSILON, 24'd0);
    write_reg(REG_LEARN_RATE, 24'hFF_FFFF);
    write_reg(REG_DECAY_FACTOR, 24'h00_FFFF);
    send_fields(32'h0000_1234, 32'h0000_0001, 32'h0);
    send_fields(32'h0000_1234, 32'hFFFF_FFFF, 32'h0);
    send_fields(32'h8000_0000, 32'h0, 32'h0);
    send_fields(32'h7FFF_FFFF, 32'h0, 32'h0);
    drain();

    // Weight decay at its extreme, beta zero and the largest epsilon.
    write_reg(REG_WEIGHT_DECAY, 24'hFF_FFFF);
    write_reg(REG_DECAY_FACTOR, 24'd0);
    write_reg(REG_EPSILON, 24'hFFFF);
    send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_fields(32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
    send_fields(32'h0000_0001, 32'h0, 32'h0);
    drain();

    // Random settings per phase; the sender holds off between phases so the
    // pipeline empties completely before each register write.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 23;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_LEARN_RATE,
                (ph == 1) ? 24'd0 : 24'($urandom_range(24'hFF_FFFF)));
      write_reg(REG_DECAY_FACTOR, 24'($urandom_range(16'hFFFF)));
      write_reg(REG_EPSILON,
                (ph == 2) ? 24'd0 : 24'($urandom_range(16'hFFFF)));
      write_reg(REG_WEIGHT_DECAY,
                (ph % 2 == 0) ? 24'd0 : 24'($urandom_range(24'hFF_FFFF)));
      send_random(135);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_rmsprop_param_update_core: PASS");
    end else begin
      $display("tb_rmsprop_param_update_core: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/rpu_pkg.sv
rtl/rmsprop_param_update_core.sv
tb/sv/tb_rmsprop_param_update_core.sv
